// File: rtl/rdr_pkg.sv
// shared types, constants and saturating arithmetic for the reaction-diffusion residual
package rdr_pkg;

  localparam int WORD_BITS = 56;
  localparam int FRAC_BITS = 32;
  localparam int CREG_BITS = WORD_BITS - 1;
  localparam int LO_BITS   = WORD_BITS / 2;
  localparam int HI_BITS   = WORD_BITS - LO_BITS;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int MUL_LAT   = 4;
  localparam int IDX_BITS  = 3;
  localparam int NUM_REGS  = 6;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        mag_t;
  typedef logic [CREG_BITS-1:0]        creg_t;
  typedef logic [PROD_BITS-1:0]        prod_t;

  typedef struct packed {
    word_t val;
    logic  clip;
  } sres_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_DIFF_U    = 3'd0,
    REG_DIFF_V    = 3'd1,
    REG_FEED_RATE = 3'd2,
    REG_KILL_RATE = 3'd3,
    REG_SCALE_X   = 3'd4,
    REG_SCALE_Y   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    creg_t diff_u;
    creg_t diff_v;
    creg_t feed_rate;
    creg_t kill_rate;
    creg_t scale_x;
    creg_t scale_y;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    diff_u:    CREG_BITS'(64'd343597),
    diff_v:    CREG_BITS'(64'd171799),
    feed_rate: CREG_BITS'(64'd103079215),
    kill_rate: CREG_BITS'(64'd257698038),
    scale_x:   CREG_BITS'(64'd45035996273705),
    scale_y:   CREG_BITS'(64'd45035996273705)
  };

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t WORD_ZERO = '0;

  // 1.0 only fits when the fraction leaves room for the integer bit
  localparam logic  ONE_CLIP = (FRAC_BITS >= WORD_BITS - 1);
  localparam word_t ONE_VAL  = ONE_CLIP ? WORD_MAX : WORD_BITS'(64'd1 << FRAC_BITS);

  localparam prod_t HALF_LSB = prod_t'(1) << (FRAC_BITS - 1);
  localparam prod_t LIM_POS  = PROD_BITS'(WORD_MAX);
  localparam prod_t LIM_NEG  = LIM_POS + prod_t'(1);

  function automatic sres_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    sres_t r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    r.clip = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic sres_t sat_sub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    sres_t r;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    r.clip = s[WORD_BITS] ^ s[WORD_BITS-1];
    r.val  = r.clip ? (s[WORD_BITS] ? WORD_MIN : WORD_MAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic word_t cfg_word(creg_t c);
    return word_t'({1'b0, c});
  endfunction

endpackage

// File: rtl/reaction_diffusion_residual_top.sv
// top level: pipelined Gray-Scott five-point stencil residual in saturating fixed point
//
//  channel  handshake            payload
//  in       start / busy         in_u_*, in_v_* (center, west, east, north, south), in_du_dt, in_dv_dt
//  out      out_valid (strobe)   out_res_u, out_res_v, out_saturated
//  cfg      cfg_we               cfg_addr, cfg_wdata
//
// one item enters every cycle; busy stays low
// a result leaves through stage 1, stage 2, the scaling multiplier, the laplacian register, the diffusion multiplier
// and the residual sum registers (two chained 4-stage multipliers set the depth); synchronous active-low reset clears
// the valid line and loads the register defaults; nothing stalls: each result is shown for one cycle and is not held
module reaction_diffusion_residual_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rdr_pkg::word_t                in_u_center,
  input  rdr_pkg::word_t                in_u_west,
  input  rdr_pkg::word_t                in_u_east,
  input  rdr_pkg::word_t                in_u_north,
  input  rdr_pkg::word_t                in_u_south,
  input  rdr_pkg::word_t                in_v_center,
  input  rdr_pkg::word_t                in_v_west,
  input  rdr_pkg::word_t                in_v_east,
  input  rdr_pkg::word_t                in_v_north,
  input  rdr_pkg::word_t                in_v_south,
  input  rdr_pkg::word_t                in_du_dt,
  input  rdr_pkg::word_t                in_dv_dt,
  input  logic                          cfg_we,
  input  logic [rdr_pkg::IDX_BITS-1:0]  cfg_addr,
  input  rdr_pkg::creg_t                cfg_wdata,
  output logic                          out_valid,
  output rdr_pkg::word_t                out_res_u,
  output rdr_pkg::word_t                out_res_v,
  output logic                          out_saturated
);

  localparam int ML      = rdr_pkg::MUL_LAT;
  localparam int DEP_P1  = 1 + ML;
  localparam int DEP_SD  = 2 + ML;
  localparam int DEP_LAP = DEP_SD + 1;
  localparam int DEP_UVV = DEP_P1 + ML;
  localparam int DEP_DL  = DEP_LAP + ML;
  localparam int DEP_R1  = DEP_DL + 1;
  localparam int LAT     = DEP_R1 + 1;
  localparam int VC_LEN  = ML;
  localparam int UVV_LEN = DEP_DL - DEP_UVV;
  localparam int PR_LEN  = DEP_R1 - DEP_P1;
  localparam int DT_LEN  = DEP_DL;

  rdr_pkg::cfg_regs_t regs;

  rdr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // valid and saturation lines
  logic [LAT:1] vld_r;
  logic [LAT:1] fl_r;
  logic [LAT:1] clip_in;

  // stage 1
  rdr_pkg::word_t uc_r, vc_r, tu_r, tv_r, omu_r, fk_r;
  rdr_pkg::word_t nb_r [8];
  rdr_pkg::sres_t nu_a, nu_b, nv_a, nv_b, omu_s, fk_s;

  // stage 2
  rdr_pkg::word_t sd_r [4];
  rdr_pkg::sres_t sd_a [4];
  rdr_pkg::sres_t sd_b [4];

  // multiplier outputs
  rdr_pkg::sres_t uv_m, uvv_m, fomu_m, fkv_m, dlu_m, dlv_m;
  rdr_pkg::sres_t sdm [4];

  // laplacians
  rdr_pkg::word_t lapu_r, lapv_r;
  rdr_pkg::sres_t lapu_s, lapv_s;

  // delay lines
  rdr_pkg::word_t vc_dl_r   [VC_LEN];
  rdr_pkg::word_t uvv_dl_r  [UVV_LEN];
  rdr_pkg::word_t fomu_dl_r [PR_LEN];
  rdr_pkg::word_t fkv_dl_r  [PR_LEN];
  rdr_pkg::word_t dudt_dl_r [DT_LEN];
  rdr_pkg::word_t dvdt_dl_r [DT_LEN];

  // final sums
  rdr_pkg::word_t ru_r, rv_r, res_u_r, res_v_r;
  rdr_pkg::sres_t ru_a, ru_b, rv_a, rv_b, fu_s, fv_s;

  assign busy = 1'b0;

  // stage 1: -2*center, 1 - u, feed + kill
  always_comb begin
    nu_a  = rdr_pkg::sat_sub(rdr_pkg::WORD_ZERO, in_u_center);
    nu_b  = rdr_pkg::sat_sub(nu_a.val, in_u_center);
    nv_a  = rdr_pkg::sat_sub(rdr_pkg::WORD_ZERO, in_v_center);
    nv_b  = rdr_pkg::sat_sub(nv_a.val, in_v_center);
    omu_s = rdr_pkg::sat_sub(rdr_pkg::ONE_VAL, in_u_center);
    fk_s  = rdr_pkg::sat_add(rdr_pkg::cfg_word(regs.feed_rate),
                             rdr_pkg::cfg_word(regs.kill_rate));
  end

  always_ff @(posedge clk) begin
    uc_r     <= in_u_center;
    vc_r     <= in_v_center;
    tu_r     <= nu_b.val;
    tv_r     <= nv_b.val;
    omu_r    <= omu_s.val;
    fk_r     <= fk_s.val;
    nb_r[0]  <= in_u_west;
    nb_r[1]  <= in_u_east;
    nb_r[2]  <= in_u_north;
    nb_r[3]  <= in_u_south;
    nb_r[4]  <= in_v_west;
    nb_r[5]  <= in_v_east;
    nb_r[6]  <= in_v_north;
    nb_r[7]  <= in_v_south;
  end

  // stage 2: second differences, order uxx uyy vxx vyy
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      sd_a[g] = rdr_pkg::sat_add((g < 2) ? tu_r : tv_r, nb_r[2*g]);
      sd_b[g] = rdr_pkg::sat_add(sd_a[g].val, nb_r[2*g+1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 4; g++) begin
      sd_r[g] <= sd_b[g].val;
    end
  end

  // products fed from stage 1, then u*v times the delayed v
  rdr_mul u_uv (.clk(clk), .a(uc_r), .b(vc_r), .res(uv_m));
  rdr_mul u_fomu (.clk(clk), .a(rdr_pkg::cfg_word(regs.feed_rate)), .b(omu_r), .res(fomu_m));
  rdr_mul u_fkv (.clk(clk), .a(fk_r), .b(vc_r), .res(fkv_m));
  rdr_mul u_uvv (.clk(clk), .a(uv_m.val), .b(vc_dl_r[VC_LEN-1]), .res(uvv_m));

  for (genvar g = 0; g < 4; g++) begin : g_sd
    rdr_mul u_sd (
      .clk (clk),
      .a   (sd_r[g]),
      .b   (((g % 2) == 0) ? rdr_pkg::cfg_word(regs.scale_x) : rdr_pkg::cfg_word(regs.scale_y)),
      .res (sdm[g])
    );
  end

  // laplacians
  always_comb begin
    lapu_s = rdr_pkg::sat_add(sdm[0].val, sdm[1].val);
    lapv_s = rdr_pkg::sat_add(sdm[2].val, sdm[3].val);
  end

  always_ff @(posedge clk) begin
    lapu_r <= lapu_s.val;
    lapv_r <= lapv_s.val;
  end

  rdr_mul u_dlu (.clk(clk), .a(rdr_pkg::cfg_word(regs.diff_u)), .b(lapu_r), .res(dlu_m));
  rdr_mul u_dlv (.clk(clk), .a(rdr_pkg::cfg_word(regs.diff_v)), .b(lapv_r), .res(dlv_m));

  // alignment lines
  always_ff @(posedge clk) begin
    vc_dl_r[0]   <= vc_r;
    uvv_dl_r[0]  <= uvv_m.val;
    fomu_dl_r[0] <= fomu_m.val;
    fkv_dl_r[0]  <= fkv_m.val;
    dudt_dl_r[0] <= in_du_dt;
    dvdt_dl_r[0] <= in_dv_dt;
    for (int k = 1; k < VC_LEN; k++) begin
      vc_dl_r[k] <= vc_dl_r[k-1];
    end
    for (int k = 1; k < UVV_LEN; k++) begin
      uvv_dl_r[k] <= uvv_dl_r[k-1];
    end
    for (int k = 1; k < PR_LEN; k++) begin
      fomu_dl_r[k] <= fomu_dl_r[k-1];
      fkv_dl_r[k]  <= fkv_dl_r[k-1];
    end
    for (int k = 1; k < DT_LEN; k++) begin
      dudt_dl_r[k] <= dudt_dl_r[k-1];
      dvdt_dl_r[k] <= dvdt_dl_r[k-1];
    end
  end

  // residual sums in two steps
  always_comb begin
    ru_a = rdr_pkg::sat_sub(dudt_dl_r[DT_LEN-1], dlu_m.val);
    ru_b = rdr_pkg::sat_add(ru_a.val, uvv_dl_r[UVV_LEN-1]);
    rv_a = rdr_pkg::sat_sub(dvdt_dl_r[DT_LEN-1], dlv_m.val);
    rv_b = rdr_pkg::sat_sub(rv_a.val, uvv_dl_r[UVV_LEN-1]);
    fu_s = rdr_pkg::sat_sub(ru_r, fomu_dl_r[PR_LEN-1]);
    fv_s = rdr_pkg::sat_add(rv_r, fkv_dl_r[PR_LEN-1]);
  end

  always_ff @(posedge clk) begin
    ru_r    <= ru_b.val;
    rv_r    <= rv_b.val;
    res_u_r <= fu_s.val;
    res_v_r <= fv_s.val;
  end

  // clip events entering the flag line at each depth
  always_comb begin
    clip_in = '0;
    clip_in[1] = rdr_pkg::ONE_CLIP | nu_a.clip | nu_b.clip | nv_a.clip | nv_b.clip
               | omu_s.clip | fk_s.clip;
    clip_in[2] = sd_a[0].clip | sd_b[0].clip | sd_a[1].clip | sd_b[1].clip
               | sd_a[2].clip | sd_b[2].clip | sd_a[3].clip | sd_b[3].clip;
    clip_in[DEP_P1+1] = clip_in[DEP_P1+1] | uv_m.clip | fomu_m.clip | fkv_m.clip;
    clip_in[DEP_LAP] = clip_in[DEP_LAP] | sdm[0].clip | sdm[1].clip | sdm[2].clip
                     | sdm[3].clip | lapu_s.clip | lapv_s.clip;
    clip_in[DEP_UVV+1] = clip_in[DEP_UVV+1] | uvv_m.clip;
    clip_in[DEP_R1] = clip_in[DEP_R1] | dlu_m.clip | dlv_m.clip | ru_a.clip | ru_b.clip
                    | rv_a.clip | rv_b.clip;
    clip_in[LAT] = clip_in[LAT] | fu_s.clip | fv_s.clip;
  end

  always_ff @(posedge clk) begin
    fl_r <= {fl_r[LAT-1:1], 1'b0} | clip_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-1:1], start};
    end
  end

  assign out_valid     = vld_r[LAT];
  assign out_res_u     = res_u_r;
  assign out_res_v     = res_v_r;
  assign out_saturated = fl_r[LAT];

`ifndef SYNTHESIS
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a transfer at the pipeline depth");
`endif

endmodule

// File: rtl/rdr_cfg.sv
// configuration register file for the reaction-diffusion residual
module rdr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rdr_pkg::IDX_BITS-1:0]  cfg_addr,
  input  rdr_pkg::creg_t                cfg_wdata,
  output rdr_pkg::cfg_regs_t            regs
);

  rdr_pkg::cfg_regs_t regs_r;
  rdr_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (rdr_pkg::reg_idx_t'(cfg_addr))
        rdr_pkg::REG_DIFF_U:    regs_nxt.diff_u    = cfg_wdata;
        rdr_pkg::REG_DIFF_V:    regs_nxt.diff_v    = cfg_wdata;
        rdr_pkg::REG_FEED_RATE: regs_nxt.feed_rate = cfg_wdata;
        rdr_pkg::REG_KILL_RATE: regs_nxt.kill_rate = cfg_wdata;
        rdr_pkg::REG_SCALE_X:   regs_nxt.scale_x   = cfg_wdata;
        rdr_pkg::REG_SCALE_Y:   regs_nxt.scale_y   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= rdr_pkg::CFG_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

`ifndef SYNTHESIS
  a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_addr >= rdr_pkg::IDX_BITS'(rdr_pkg::NUM_REGS))) |=> $stable(regs_r))
    else $error("write to unknown register index changed the register file");
`endif

endmodule

// File: rtl/rdr_mul.sv
// four-stage saturating fixed-point multiplier built from half-width partial products
module rdr_mul (
  input  logic           clk,
  input  rdr_pkg::word_t a,
  input  rdr_pkg::word_t b,
  output rdr_pkg::sres_t res
);

  localparam int W  = rdr_pkg::WORD_BITS;
  localparam int LO = rdr_pkg::LO_BITS;
  localparam int HI = rdr_pkg::HI_BITS;

  // stage 1: sign and magnitudes
  logic          neg1_r;
  rdr_pkg::mag_t mag_a_r, mag_b_r;
  rdr_pkg::mag_t mag_a_nxt, mag_b_nxt;

  // stage 2: partial products
  logic              neg2_r;
  logic [2*LO-1:0]   ll_r;
  logic [LO+HI-1:0]  lh_r, hl_r;
  logic [2*HI-1:0]   hh_r;

  // stage 3: full product plus rounding half
  logic           neg3_r;
  rdr_pkg::prod_t sum_r;

  // stage 4: scale, clip, sign
  rdr_pkg::prod_t q;
  rdr_pkg::prod_t lim;
  rdr_pkg::mag_t  qmag;
  rdr_pkg::sres_t res_nxt;
  rdr_pkg::sres_t res_r;

  assign mag_a_nxt = a[W-1] ? (rdr_pkg::mag_t'(~a) + rdr_pkg::mag_t'(1)) : rdr_pkg::mag_t'(a);
  assign mag_b_nxt = b[W-1] ? (rdr_pkg::mag_t'(~b) + rdr_pkg::mag_t'(1)) : rdr_pkg::mag_t'(b);

  always_comb begin
    q    = sum_r >> rdr_pkg::FRAC_BITS;
    lim  = neg3_r ? rdr_pkg::LIM_NEG : rdr_pkg::LIM_POS;
    qmag = q[W-1:0];
    res_nxt.clip = (q > lim);
    if (res_nxt.clip) begin
      res_nxt.val = neg3_r ? rdr_pkg::WORD_MIN : rdr_pkg::WORD_MAX;
    end else if (neg3_r) begin
      res_nxt.val = rdr_pkg::word_t'(rdr_pkg::mag_t'(~qmag) + rdr_pkg::mag_t'(1));
    end else begin
      res_nxt.val = rdr_pkg::word_t'(qmag);
    end
  end

  always_ff @(posedge clk) begin
    neg1_r  <= a[W-1] ^ b[W-1];
    mag_a_r <= mag_a_nxt;
    mag_b_r <= mag_b_nxt;

    neg2_r <= neg1_r;
    ll_r   <= (2*LO)'(mag_a_r[LO-1:0]) * (2*LO)'(mag_b_r[LO-1:0]);
    lh_r   <= (LO+HI)'(mag_a_r[LO-1:0]) * (LO+HI)'(mag_b_r[W-1:LO]);
    hl_r   <= (LO+HI)'(mag_a_r[W-1:LO]) * (LO+HI)'(mag_b_r[LO-1:0]);
    hh_r   <= (2*HI)'(mag_a_r[W-1:LO]) * (2*HI)'(mag_b_r[W-1:LO]);

    neg3_r <= neg2_r;
    sum_r  <= (rdr_pkg::prod_t'(hh_r) << (2 * LO))
            + ((rdr_pkg::prod_t'(lh_r) + rdr_pkg::prod_t'(hl_r)) << LO)
            + rdr_pkg::prod_t'(ll_r) + rdr_pkg::HALF_LSB;

    res_r <= res_nxt;
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_clip_at_bound: assert property (@(posedge clk)
    res_r.clip |-> (res_r.val == rdr_pkg::WORD_MAX || res_r.val == rdr_pkg::WORD_MIN))
    else $error("clipped product is not at a word bound");
`endif

endmodule
